>>> rtl/ppw_pkg.sv
// Shared types and constants for the polyline path walker.
// Used by polyline_path_walker_core and ppw_checker; no dependencies.
package ppw_pkg;

	// default depth of the segment table
	localparam int DEF_MAX_SEGMENTS = 64;

	// field widths
	localparam int CMD_W     = 2;
	localparam int SLOT_W    = 6;
	localparam int DIR_W     = 16;
	localparam int LEN_W     = 24;
	localparam int HEAD_W    = 16;
	localparam int OFF_W     = 32;
	localparam int CFG_W     = 7;
	localparam int IN_DATA_W = 104;
	localparam int OUT_DATA_W = 88;

	// item kinds carried on the input tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_WALK    = 2'd2
	} cmd_t;

	// one segment table entry
	typedef struct packed {
		logic [HEAD_W-1:0]       heading;
		logic [LEN_W-1:0]        length;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_x;
	} seg_entry_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RDH  = 6'b000010,
		ST_LAT  = 6'b000100,
		ST_STEP = 6'b001000,
		ST_ACC  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

endpackage

>>> rtl/polyline_path_walker_core.sv
// Polyline path walker: segment table in one synchronous RAM plus a walk sequencer.
// Depends on ppw_pkg.
//
// Usage:
//  s_tvalid/s_tready/s_tuser/s_tdata carry command items. tuser is the command
//  (load segment, restart at segment zero, walk a distance); tdata carries the
//  segment slot and contents of a load and the distance of a walk.
//  m_tvalid/m_tready/m_tuser/m_tdata return one result item per command: the
//  offset made by the walk, the current segment, its heading and the finished flag.
//  cfg_wr_en/cfg_wr_data write the count of segments in use; write it only while idle.
// Sequence (from accept to result valid and s_tready high again, which rise together):
//  a load or unused command passes ST_RDH, ST_LAT and ST_OUT; a restart passes ST_LAT
//  and ST_OUT; a walk alternates ST_STEP and ST_ACC for each segment touched, then
//  ST_OUT (straight from ST_ACC when the end of the path is hit). Each segment touched
//  costs one table read and one multiply, which sets the walk rate.
// Reset clears the walk position, the finished flag and the output valid; the segment
//  table is not cleared and must be loaded before a restart or walk reads it.
// If the receiver stalls, the result holds in the output register; the block still
//  takes and works on one more item and parks its result until the register frees.
module polyline_path_walker_core #(
	parameter int MAX_SEGMENTS = ppw_pkg::DEF_MAX_SEGMENTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ppw_pkg::CMD_W-1:0]     s_tuser,  // [1:0] cmd
	// [5:0] seg_index, [21:6] dir_x, [37:22] dir_y, [61:38] seg_length,
	// [77:62] heading_in, [101:78] walk_distance, [103:102] zero
	input  logic [ppw_pkg::IN_DATA_W-1:0] s_tdata,
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic                          m_tuser,  // [0] finished
	// [31:0] offset_x, [63:32] offset_y, [79:64] heading_out,
	// [85:80] current_segment, [87:86] zero
	output logic [ppw_pkg::OUT_DATA_W-1:0] m_tdata,
	// segments_in_use register
	input  logic                          cfg_wr_en,
	input  logic [ppw_pkg::CFG_W-1:0]     cfg_wr_data
);

	localparam int IDXW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW   = (IDXW + 1 > ppw_pkg::CFG_W) ? IDXW + 1 : ppw_pkg::CFG_W;
	localparam int PW   = ppw_pkg::DIR_W + ppw_pkg::LEN_W + 1;

	// input field split
	ppw_pkg::cmd_t                 in_cmd;
	logic [ppw_pkg::SLOT_W-1:0]    in_slot;
	ppw_pkg::seg_entry_t           in_entry;
	logic [ppw_pkg::LEN_W-1:0]     in_dist;

	assign in_cmd           = ppw_pkg::cmd_t'(s_tuser);
	assign in_slot          = s_tdata[5:0];
	assign in_entry.dir_x   = s_tdata[21:6];
	assign in_entry.dir_y   = s_tdata[37:22];
	assign in_entry.length  = s_tdata[61:38];
	assign in_entry.heading = s_tdata[77:62];
	assign in_dist          = s_tdata[101:78];

	// control and walk state
	ppw_pkg::state_t               state_q;
	logic [ppw_pkg::CFG_W-1:0]     cfg_q;
	logic [IDXW-1:0]               seg_q;
	logic [ppw_pkg::LEN_W-1:0]     len_q;
	logic                          done_q;
	logic                          restart_q;
	logic                          adv_q;
	logic                          stop_q;
	logic [ppw_pkg::LEN_W-1:0]     dist_q;
	logic signed [ppw_pkg::OFF_W-1:0] off_x_q;
	logic signed [ppw_pkg::OFF_W-1:0] off_y_q;
	logic signed [PW-1:0]          prod_x_s1;
	logic signed [PW-1:0]          prod_y_s1;

	// segment table
	ppw_pkg::seg_entry_t           mem [MAX_SEGMENTS];
	ppw_pkg::seg_entry_t           rd_q;
	logic                          wr_en;
	logic [IDXW-1:0]               wr_addr;
	logic                          rd_en;
	logic [IDXW-1:0]               rd_addr;

	// output register
	logic signed [ppw_pkg::OFF_W-1:0] out_x_q;
	logic signed [ppw_pkg::OFF_W-1:0] out_y_q;
	logic [ppw_pkg::HEAD_W-1:0]    out_head_q;
	logic [ppw_pkg::SLOT_W-1:0]    out_seg_q;
	logic                          out_done_q;
	logic                          out_valid_q;

	logic                          in_acc;
	logic                          out_free;
	logic [31:0]                   slot_ext;
	logic                          slot_ok;
	logic [CW-1:0]                 seg_next;
	logic                          next_ok;
	logic                          dist_gt;
	logic [ppw_pkg::LEN_W-1:0]     covered;
	logic signed [PW-1:0]          rnd_x;
	logic signed [PW-1:0]          rnd_y;
	logic signed [PW-1:0]          sh_x;
	logic signed [PW-1:0]          sh_y;
	logic [31:0]                   seg_ext;

	assign s_tready = (state_q == ppw_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// load slot range check and table address
	assign slot_ext = 32'(in_slot);
	assign slot_ok  = (slot_ext < 32'(MAX_SEGMENTS));
	assign wr_en    = in_acc && (in_cmd == ppw_pkg::CMD_LOAD) && slot_ok;
	assign wr_addr  = slot_ext[IDXW-1:0];

	// step decisions
	assign seg_next = CW'(seg_q) + CW'(1);
	assign next_ok  = (seg_next < CW'(cfg_q)) && (seg_next < CW'(MAX_SEGMENTS));
	assign dist_gt  = dist_q > len_q;
	assign covered  = dist_gt ? len_q : dist_q;

	// table read port address
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = seg_q;
		unique case (state_q)
			ppw_pkg::ST_IDLE: begin
				if (in_acc && in_cmd == ppw_pkg::CMD_WALK) begin
					rd_en = 1'b1;
				end else if (in_acc && in_cmd == ppw_pkg::CMD_RESTART) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			ppw_pkg::ST_RDH: begin
				rd_en = 1'b1;
			end
			ppw_pkg::ST_STEP: begin
				if (dist_q != '0 && dist_gt && next_ok) begin
					rd_en   = 1'b1;
					rd_addr = seg_next[IDXW-1:0];
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// segment table RAM, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= in_entry;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// direction times covered distance
	always_ff @(posedge clk) begin
		if (state_q == ppw_pkg::ST_STEP) begin
			prod_x_s1 <= PW'(rd_q.dir_x) * PW'($signed({1'b0, covered}));
			prod_y_s1 <= PW'(rd_q.dir_y) * PW'($signed({1'b0, covered}));
		end
	end

	// round half up to Q24.8
	assign rnd_x = prod_x_s1 + PW'(16384);
	assign rnd_y = prod_y_s1 + PW'(16384);
	assign sh_x  = rnd_x >>> 15;
	assign sh_y  = rnd_y >>> 15;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ppw_pkg::ST_IDLE;
			cfg_q     <= ppw_pkg::CFG_W'(1);
			seg_q     <= '0;
			len_q     <= '0;
			done_q    <= 1'b0;
			restart_q <= 1'b0;
			adv_q     <= 1'b0;
			stop_q    <= 1'b0;
			dist_q    <= '0;
			off_x_q   <= '0;
			off_y_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			unique case (state_q)
				ppw_pkg::ST_IDLE: begin
					if (in_acc) begin
						off_x_q   <= '0;
						off_y_q   <= '0;
						dist_q    <= in_dist;
						restart_q <= 1'b0;
						case (in_cmd)
							ppw_pkg::CMD_WALK: begin
								state_q <= ppw_pkg::ST_STEP;
							end
							ppw_pkg::CMD_RESTART: begin
								seg_q     <= '0;
								done_q    <= 1'b0;
								restart_q <= 1'b1;
								state_q   <= ppw_pkg::ST_LAT;
							end
							default: begin
								state_q <= ppw_pkg::ST_RDH;
							end
						endcase
					end
				end
				ppw_pkg::ST_RDH: begin
					state_q <= ppw_pkg::ST_LAT;
				end
				ppw_pkg::ST_LAT: begin
					if (restart_q) begin
						len_q <= rd_q.length;
					end
					state_q <= ppw_pkg::ST_OUT;
				end
				ppw_pkg::ST_STEP: begin
					adv_q  <= 1'b0;
					stop_q <= 1'b0;
					if (dist_q == '0) begin
						state_q <= ppw_pkg::ST_OUT;
					end else begin
						state_q <= ppw_pkg::ST_ACC;
						if (dist_gt) begin
							dist_q <= dist_q - len_q;
							if (next_ok) begin
								seg_q <= seg_next[IDXW-1:0];
								adv_q <= 1'b1;
							end else begin
								done_q <= 1'b1;
								len_q  <= '0;
								stop_q <= 1'b1;
							end
						end else begin
							len_q  <= len_q - dist_q;
							dist_q <= '0;
						end
					end
				end
				ppw_pkg::ST_ACC: begin
					off_x_q <= off_x_q + sh_x[ppw_pkg::OFF_W-1:0];
					off_y_q <= off_y_q + sh_y[ppw_pkg::OFF_W-1:0];
					if (adv_q) begin
						len_q <= rd_q.length;
					end
					state_q <= stop_q ? ppw_pkg::ST_OUT : ppw_pkg::ST_STEP;
				end
				ppw_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= ppw_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ppw_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign seg_ext = 32'(seg_q);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ppw_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ppw_pkg::ST_OUT && out_free) begin
			out_x_q    <= off_x_q;
			out_y_q    <= off_y_q;
			out_head_q <= rd_q.heading;
			out_seg_q  <= seg_ext[ppw_pkg::SLOT_W-1:0];
			out_done_q <= done_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_done_q;
	assign m_tdata  = {2'b00, out_seg_q, out_head_q, out_y_q, out_x_q};

endmodule

>>> rtl/ppw_checker.sv
// Port-level checks for polyline_path_walker_core, bound into that module.
// Depends on ppw_pkg.
module ppw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic                           m_tuser,
	input logic [ppw_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input taken again right after an accept");

	// at most one parked result plus one in work
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items outstanding");

	// no result without an accepted item
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result with no item outstanding");

endmodule

bind polyline_path_walker_core ppw_checker u_ppw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);
